[design/dbba_pkg.sv]
// Shared constants, codes and types of the data block bitmap allocator.
// No dependencies; every other design file refers to it by scoped names.
package dbba_pkg;

    // Bitmap geometry
    localparam int WORDS_PER_MAP = 128;
    localparam int MAX_MAPS      = 4;
    localparam int TOTAL_WORDS   = WORDS_PER_MAP * MAX_MAPS;
    localparam int ADDR_W        = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int WCNT_W        = $clog2(TOTAL_WORDS + 1);
    localparam int WORD_W        = 64;
    localparam int BIT_W         = 6;
    localparam int BYTE_N        = WORD_W / 8;
    localparam int BYTE_W        = 3;

    // Field widths
    localparam int BLK_W      = 20;
    localparam int META_W     = 16;
    localparam int MAPS_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = ADDR_W + BIT_W;
    localparam int SUM_A      = (IDX_W > META_W) ? IDX_W : META_W;
    localparam int SUM_W      = ((SUM_A > BLK_W) ? SUM_A : BLK_W) + 1;
    localparam int FWORD_W    = BLK_W - BIT_W;
    localparam int CMP_W      = (FWORD_W > WCNT_W) ? FWORD_W : WCNT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = META_W;
    localparam logic [CFG_IDX_W-1:0] CFG_METADATA_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAPS_IN_USE     = 1'b1;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ERROR     = 2'd3;

    typedef struct packed {
        logic             op;
        logic [BLK_W-1:0] blk;
    } t_req;

    typedef struct packed {
        logic [META_W-1:0] meta;
        logic [WCNT_W-1:0] limit;   // words scanned and checked
    } t_cfg;

    typedef struct packed {
        logic [BLK_W-1:0]    blk;
        logic [STATUS_W-1:0] status;
    } t_rsp;

endpackage

[design/dbba_find_zero.sv]
// Two-stage search for the lowest clear bit of a 64-bit bitmap word.
// Depends on dbba_pkg.
module dbba_find_zero (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dbba_pkg::WORD_W-1:0] i_word,
    output logic                        o_valid,
    output logic [dbba_pkg::BIT_W-1:0]  o_bit
);

    logic                         r_s1_vld;
    logic [dbba_pkg::BYTE_N-1:0]  r_zf;
    logic [dbba_pkg::BYTE_W-1:0]  r_loc [dbba_pkg::BYTE_N];
    logic [dbba_pkg::BYTE_N-1:0]  n_zf;
    logic [dbba_pkg::BYTE_W-1:0]  n_loc [dbba_pkg::BYTE_N];
    logic                         r_vld;
    logic [dbba_pkg::BIT_W-1:0]   r_bit;
    logic [dbba_pkg::BIT_W-1:0]   n_bit;
    logic                         sel_found;

    // Stage 1: per byte, any clear bit and the lowest one
    always_comb begin
        for (int i = 0; i < dbba_pkg::BYTE_N; i++) begin
            n_zf[i]  = ~&i_word[i*8 +: 8];
            n_loc[i] = '0;
            for (int j = 7; j >= 0; j--) begin
                if (!i_word[i*8 + j]) begin
                    n_loc[i] = dbba_pkg::BYTE_W'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
        end
        r_zf  <= n_zf;
        r_loc <= n_loc;
    end

    // Stage 2: lowest byte that holds a clear bit
    always_comb begin
        n_bit     = '0;
        sel_found = 1'b0;
        for (int i = 0; i < dbba_pkg::BYTE_N; i++) begin
            if (r_zf[i] && !sel_found) begin
                n_bit     = {dbba_pkg::BYTE_W'(i), r_loc[i]};
                sel_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r_s1_vld;
        end
        r_bit <= n_bit;
    end

    assign o_valid = r_vld;
    assign o_bit   = r_bit;

endmodule

[design/dbba_core.sv]
// Sequencer and bitmap memory: clearing pass, first-fit scan and free check.
// Depends on dbba_pkg and dbba_find_zero.
module dbba_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dbba_pkg::t_cfg i_cfg,
    input  logic           i_req_valid,
    input  dbba_pkg::t_req i_req,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    output dbba_pkg::t_rsp o_rsp,
    input  logic           i_rsp_ready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_FIDX  = 3'd4;
    localparam logic [2:0] S_FRD   = 3'd5;
    localparam logic [2:0] S_FCHK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Bitmap memory
    logic [dbba_pkg::WORD_W-1:0] mem [dbba_pkg::TOTAL_WORDS];
    logic                        we;
    logic [dbba_pkg::ADDR_W-1:0] wa;
    logic [dbba_pkg::WORD_W-1:0] wd;
    logic [dbba_pkg::ADDR_W-1:0] ra;
    logic [dbba_pkg::WORD_W-1:0] r_rd_data;

    logic [2:0]                  r_state, n_state;
    logic [dbba_pkg::WCNT_W-1:0] r_cnt, n_cnt;
    logic                        r_rd_vld, n_rd_vld;
    logic [dbba_pkg::ADDR_W-1:0] r_rd_addr;
    logic [dbba_pkg::ADDR_W-1:0] r_hit, n_hit;
    logic [dbba_pkg::WORD_W-1:0] r_word, n_word;
    logic [dbba_pkg::BIT_W-1:0]  r_bit, n_bit;
    dbba_pkg::t_req              r_req, n_req;
    dbba_pkg::t_rsp              r_rsp, n_rsp;

    logic                        fz_start;
    logic                        fz_valid;
    logic [dbba_pkg::BIT_W-1:0]  fz_bit;

    logic [dbba_pkg::BLK_W:0]    diff;
    logic [dbba_pkg::CMP_W-1:0]  free_word;
    logic [dbba_pkg::SUM_W-1:0]  alloc_sum;
    logic                        issue;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_data <= mem[ra];
    end

    dbba_find_zero u_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fz_start),
        .i_word  (r_rd_data),
        .o_valid (fz_valid),
        .o_bit   (fz_bit)
    );

    // Free path: index below offset shows as a borrow
    assign diff      = {1'b0, i_req.blk} - (dbba_pkg::BLK_W + 1)'(i_cfg.meta);
    assign free_word = dbba_pkg::CMP_W'(r_req.blk[dbba_pkg::BLK_W-1:dbba_pkg::BIT_W]);
    // Allocate path: global number of the hit bit
    assign alloc_sum = dbba_pkg::SUM_W'({r_hit, fz_bit}) + dbba_pkg::SUM_W'(i_cfg.meta);
    assign issue     = r_cnt < i_cfg.limit;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd_vld    = 1'b0;
        n_hit       = r_hit;
        n_word      = r_word;
        n_bit       = r_bit;
        n_req       = r_req;
        n_rsp       = r_rsp;
        we          = 1'b0;
        wa          = r_hit;
        wd          = '0;
        ra          = r_cnt[dbba_pkg::ADDR_W-1:0];
        fz_start    = 1'b0;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                wa = r_cnt[dbba_pkg::ADDR_W-1:0];
                if (r_cnt == dbba_pkg::WCNT_W'(dbba_pkg::TOTAL_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                n_cnt       = '0;
                if (i_req_valid) begin
                    n_req     = i_req;
                    n_rsp.blk = '0;
                    if (i_req.op == dbba_pkg::OP_ALLOC) begin
                        if (i_cfg.limit == '0) begin
                            n_rsp.status = dbba_pkg::ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        // keep the offset-corrected index for the range check
                        n_req.blk = diff[dbba_pkg::BLK_W-1:0];
                        n_bit     = {dbba_pkg::BIT_W{diff[dbba_pkg::BLK_W]}};
                        n_state   = S_FIDX;
                    end
                end
            end
            S_SCAN: begin
                // one read per cycle, result checked in the cycle after
                n_rd_vld = issue;
                if (issue) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_rd_vld) begin
                    if (r_rd_data != '1) begin
                        n_word   = r_rd_data;
                        n_hit    = r_rd_addr;
                        fz_start = 1'b1;
                        n_rd_vld = 1'b0;
                        n_state  = S_FIND;
                    end else if (dbba_pkg::WCNT_W'(r_rd_addr) + 1'b1 == i_cfg.limit) begin
                        n_rsp.status = dbba_pkg::ST_FULL;
                        n_rd_vld     = 1'b0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_FIND: begin
                if (fz_valid) begin
                    we           = 1'b1;
                    wd           = r_word | (dbba_pkg::WORD_W'(1) << fz_bit);
                    n_rsp.blk    = alloc_sum[dbba_pkg::BLK_W-1:0];
                    n_rsp.status = dbba_pkg::ST_ALLOCATED;
                    n_state      = S_DONE;
                end
            end
            S_FIDX: begin
                // r_bit all ones here marks a borrow from the offset subtract
                if (r_bit[0] || free_word >= dbba_pkg::CMP_W'(i_cfg.limit)) begin
                    n_rsp.status = dbba_pkg::ST_ERROR;
                    n_state      = S_DONE;
                end else begin
                    n_hit   = free_word[dbba_pkg::ADDR_W-1:0];
                    n_bit   = r_req.blk[dbba_pkg::BIT_W-1:0];
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                ra      = r_hit;
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (r_rd_data[r_bit]) begin
                    we           = 1'b1;
                    wd           = r_rd_data & ~(dbba_pkg::WORD_W'(1) << r_bit);
                    n_rsp.status = dbba_pkg::ST_FREED;
                end else begin
                    n_rsp.status = dbba_pkg::ST_ERROR;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
        end
        r_rd_addr <= ra;
        r_hit     <= n_hit;
        r_word    <= n_word;
        r_bit     <= n_bit;
        r_req     <= n_req;
        r_rsp     <= n_rsp;
    end

    assign o_rsp = r_rsp;

endmodule

[design/data_block_bitmap_allocator_unit.sv]
// Top level of the data block bitmap allocator: stream ports, configuration
// registers and output register. Depends on dbba_pkg and dbba_core.
//
//  Channel   Direction  Beat fields (low bit first)
//  s_axis    in         tuser: operation | tdata: block_number (20, padded to 24)
//  m_axis    out        tuser: status    | tdata: allocated_block (20, padded to 24)
//  cfg       in         idx 0 metadata_blocks (16), idx 1 maps_in_use (3)
//
// After reset the bitmap is cleared one word a cycle, all 512 words, with
// s_axis not ready. An allocate reads the words in order over the single
// memory read port, one read per cycle, until one has a clear bit, and sets
// the lowest such bit. A free checks the range, reads the word and clears
// the bit if set; a failed range check ends it. One item is in work at a
// time; the output register holds a result while the next is taken.
module data_block_bitmap_allocator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [23:0]                     i_s_axis_tdata,   // block_number
    input  logic                            i_s_axis_tuser,   // operation
    // output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [23:0]                     o_m_axis_tdata,   // allocated_block
    output logic [dbba_pkg::STATUS_W-1:0]   o_m_axis_tuser,   // status
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [dbba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbba_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [dbba_pkg::META_W-1:0] r_meta;
    logic [dbba_pkg::WCNT_W-1:0] r_limit;
    logic [dbba_pkg::WCNT_W-1:0] n_limit;
    logic [dbba_pkg::MAPS_W-1:0] maps;
    logic [dbba_pkg::WCNT_W-1:0] maps_clamped;

    dbba_pkg::t_cfg cfg;
    dbba_pkg::t_req req;
    dbba_pkg::t_rsp rsp;
    logic           rsp_valid;
    logic           rsp_ready;

    logic                  r_out_valid;
    dbba_pkg::t_rsp        r_out;

    // Word limit from the map count, clamped to the maps that exist
    assign maps         = i_cfg_data[dbba_pkg::MAPS_W-1:0];
    assign maps_clamped = (32'(maps) > dbba_pkg::MAX_MAPS)
                        ? dbba_pkg::WCNT_W'(dbba_pkg::MAX_MAPS)
                        : dbba_pkg::WCNT_W'(maps);
    assign n_limit      = dbba_pkg::WCNT_W'(maps_clamped
                        * dbba_pkg::WCNT_W'(dbba_pkg::WORDS_PER_MAP));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta  <= '0;
            r_limit <= dbba_pkg::WCNT_W'(dbba_pkg::WORDS_PER_MAP);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dbba_pkg::CFG_METADATA_BLOCKS: r_meta  <= i_cfg_data;
                dbba_pkg::CFG_MAPS_IN_USE:     r_limit <= n_limit;
                default: ;
            endcase
        end
    end

    assign cfg.meta  = r_meta;
    assign cfg.limit = r_limit;
    assign req.op    = i_s_axis_tuser;
    assign req.blk   = i_s_axis_tdata[dbba_pkg::BLK_W-1:0];

    dbba_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_s_axis_tvalid),
        .i_req       (req),
        .o_req_ready (o_s_axis_tready),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_rsp_ready (rsp_ready)
    );

    // Output register
    assign rsp_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_ready) begin
            r_out_valid <= rsp_valid;
        end
        if (rsp_ready && rsp_valid) begin
            r_out <= rsp;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 24'(r_out.blk);
    assign o_m_axis_tuser  = r_out.status;

endmodule
